FILE: hw/rtl/xxtea_pkg.sv
// Package with constants, register codes and the mix function of the XXTEA core.
package xxtea_pkg;

  localparam int unsigned WordWidth = 32;

  typedef logic [WordWidth-1:0] word_t;

  // Round constant added to the running sum once per round
  localparam word_t TeaDelta = 32'h9E37_79B9;

  // Key words after reset
  localparam word_t KeyReset0 = 32'h6C0A_5452;
  localparam word_t KeyReset1 = 32'h0382_7D0F;
  localparam word_t KeyReset2 = 32'h3A17_0B92;
  localparam word_t KeyReset3 = 32'h16DB_7FC2;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CfgKeyWord0    = 3'd0,
    CfgKeyWord1    = 3'd1,
    CfgKeyWord2    = 3'd2,
    CfgKeyWord3    = 3'd3,
    CfgDecryptMode = 3'd4
  } cfg_addr_e;

  // Mix term for a two-word block: both neighbors are the same word
  function automatic word_t xx_mix(word_t w, word_t sum, word_t key);
    word_t a;
    word_t b;
    a = ((w >> 5) ^ (w << 2)) + ((w >> 3) ^ (w << 4));
    b = (sum ^ w) + (key ^ w);
    return a ^ b;
  endfunction

endpackage

FILE: hw/rtl/xxtea_block_cipher_64_core.sv
// Top level of the pipelined XXTEA 64-bit block cipher core.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------
//  input    | in_valid_i/in_stall_o | block_word0_i, block_word1_i
//  output   | out_valid_o/out_stall_i | result_word0_o, result_word1_o
//  config   | cfg_valid_i/cfg_ready_o | cfg_addr_i, cfg_data_i
//
// One block is accepted every cycle while in_stall_o is low. Each of the 2*ROUNDS pipeline
// stages does one half of a cipher round (one mix and one add or subtract into a word),
// and the last stage feeds the output register.
// Reset restores the default key and selects encipher; the pipeline comes up empty.
// A stalled result parks in a one-entry skid register; only while that is full does
// the pipeline freeze and in_stall_o rise.
module xxtea_block_cipher_64_core #(
  parameter int unsigned ROUNDS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // block input
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  xxtea_pkg::word_t     block_word0_i,
  input  xxtea_pkg::word_t     block_word1_i,
  // block output
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output xxtea_pkg::word_t     result_word0_o,
  output xxtea_pkg::word_t     result_word1_o,
  // configuration writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  xxtea_pkg::cfg_addr_e cfg_addr_i,
  input  xxtea_pkg::word_t     cfg_data_i
);
  import xxtea_pkg::*;

  localparam int unsigned NumStages = 2 * ROUNDS;

  // Configuration registers
  word_t key_q [4];
  logic  decrypt_q;

  // Pipeline registers
  logic [NumStages-1:0] vld_q;
  word_t                w0_q [NumStages];
  word_t                w1_q [NumStages];
  word_t                w0_d [NumStages];
  word_t                w1_d [NumStages];

  // Output and skid registers
  logic  out_vld_q, skid_vld_q;
  word_t out_w0_q, out_w1_q, skid_w0_q, skid_w1_q;

  logic advance;
  logic out_take;

  assign cfg_ready_o = 1'b1;

  // Take configuration writes; ignore unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q[0]  <= KeyReset0;
      key_q[1]  <= KeyReset1;
      key_q[2]  <= KeyReset2;
      key_q[3]  <= KeyReset3;
      decrypt_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_addr_i)
        CfgKeyWord0:    key_q[0]  <= cfg_data_i;
        CfgKeyWord1:    key_q[1]  <= cfg_data_i;
        CfgKeyWord2:    key_q[2]  <= cfg_data_i;
        CfgKeyWord3:    key_q[3]  <= cfg_data_i;
        CfgDecryptMode: decrypt_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Pipeline moves whenever the skid register is free
  assign advance    = !skid_vld_q;
  assign in_stall_o = skid_vld_q;
  assign out_take   = out_vld_q && !out_stall_i;

  // Advance valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (advance) begin
      vld_q <= {vld_q[NumStages-2:0], in_valid_i};
    end
  end

  // Build one half-round stage per pipeline slot
  for (genvar g = 0; g < NumStages; g++) begin : g_stage
    localparam int unsigned RoundIdx = g / 2;
    localparam logic        PEnc     = (g % 2) != 0;
    localparam logic        PDec     = (g % 2) == 0;
    localparam word_t       SumEnc   =
      32'((64'(RoundIdx) + 64'd1) * 64'(TeaDelta));
    localparam word_t       SumDec   =
      32'(64'(ROUNDS - RoundIdx) * 64'(TeaDelta));
    localparam logic [1:0]  KeyEnc   = {1'b0, PEnc} ^ SumEnc[3:2];
    localparam logic [1:0]  KeyDec   = {1'b0, PDec} ^ SumDec[3:2];

    word_t src_w0, src_w1, other, target, sum_sel, key_sel, mixed, updated;
    logic  tgt_is_1;

    if (g == 0) begin : g_first
      assign src_w0 = block_word0_i;
      assign src_w1 = block_word1_i;
    end else begin : g_next
      assign src_w0 = w0_q[g-1];
      assign src_w1 = w1_q[g-1];
    end

    // Pick word, sum and key word for this direction
    always_comb begin
      tgt_is_1 = decrypt_q ? PDec : PEnc;
      sum_sel  = decrypt_q ? SumDec : SumEnc;
      key_sel  = decrypt_q ? key_q[KeyDec] : key_q[KeyEnc];
      target   = tgt_is_1 ? src_w1 : src_w0;
      other    = tgt_is_1 ? src_w0 : src_w1;
      mixed    = xx_mix(other, sum_sel, key_sel);
      updated  = decrypt_q ? (target - mixed) : (target + mixed);
      w0_d[g]  = tgt_is_1 ? src_w0 : updated;
      w1_d[g]  = tgt_is_1 ? updated : src_w1;
    end

    // Advance payload
    always_ff @(posedge clk_i) begin
      if (advance) begin
        w0_q[g] <= w0_d[g];
        w1_q[g] <= w1_d[g];
      end
    end
  end

  // Output register and skid control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (advance) begin
      if (!out_vld_q || out_take) begin
        out_vld_q <= vld_q[NumStages-1];
      end else if (vld_q[NumStages-1]) begin
        skid_vld_q <= 1'b1;
      end
    end else if (out_take) begin
      skid_vld_q <= 1'b0;
    end
  end

  // Output and skid payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      if (!out_vld_q || out_take) begin
        out_w0_q <= w0_q[NumStages-1];
        out_w1_q <= w1_q[NumStages-1];
      end else begin
        skid_w0_q <= w0_q[NumStages-1];
        skid_w1_q <= w1_q[NumStages-1];
      end
    end else if (out_take) begin
      out_w0_q <= skid_w0_q;
      out_w1_q <= skid_w1_q;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign result_word0_o = out_w0_q;
  assign result_word1_o = out_w1_q;

  // A full skid register always sits behind a pending result
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("skid register full while output register empty");

  // Skid holds while the output stays stalled
  a_skid_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_stall_o && out_stall_i) |=> in_stall_o)
    else $error("skid register dropped an entry under stall");

  // Skid drains in the cycle after the result is taken
  a_skid_drains : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_stall_o && !out_stall_i) |=> !in_stall_o)
    else $error("skid register did not drain after output transaction");

endmodule

FILE: tb/xxtea_block_cipher_64_core_test.sv
// Testbench for the XXTEA 64-bit block cipher core: directed and random blocks checked against a predictor.
module xxtea_block_cipher_64_core_test;
  import xxtea_pkg::*;

  localparam int unsigned Rounds     = 32;
  localparam int unsigned Latency    = 2 * Rounds + 1;
  localparam int unsigned MaxReports = 10;

  typedef struct packed {
    word_t w0;
    word_t w1;
  } cipher_block_t;

  logic      clk_i         = 1'b0;
  logic      rst_ni        = 1'b0;
  logic      in_valid_i    = 1'b0;
  logic      in_stall_o;
  word_t     block_word0_i = '0;
  word_t     block_word1_i = '0;
  logic      out_valid_o;
  logic      out_stall_i   = 1'b0;
  word_t     result_word0_o;
  word_t     result_word1_o;
  logic      cfg_valid_i   = 1'b0;
  logic      cfg_ready_o;
  cfg_addr_e cfg_addr_i    = CfgKeyWord0;
  word_t     cfg_data_i    = '0;

  // Predictor copy of the configuration
  word_t key_model [4];
  logic  decipher_model;

  cipher_block_t expected_blocks[$];
  int unsigned   mismatch_count = 0;
  int unsigned   send_idle_pct  = 0;
  int unsigned   recv_stall_pct = 0;

  xxtea_block_cipher_64_core #(
    .ROUNDS(Rounds)
  ) uut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .block_word0_i,
    .block_word1_i,
    .out_valid_o,
    .out_stall_i,
    .result_word0_o,
    .result_word1_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_addr_i,
    .cfg_data_i
  );

  always #1 clk_i = ~clk_i;

  // Mixing term for word position pos with neighbors y (next) and z (previous)
  function automatic word_t round_mix(word_t y, word_t z, word_t sum, int unsigned pos,
                                      word_t sel);
    word_t a;
    word_t b;
    a = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
    b = (sum ^ y) + (key_model[2'(pos) ^ sel[1:0]] ^ z);
    return a ^ b;
  endfunction

  // Encipher or decipher one two-word block under the current model settings
  function automatic cipher_block_t xxtea_transform(word_t w0, word_t w1);
    word_t         v0;
    word_t         v1;
    word_t         sum;
    word_t         sel;
    cipher_block_t res;
    v0 = w0;
    v1 = w1;
    if (!decipher_model) begin
      sum = '0;
      for (int unsigned r = 0; r < Rounds; r++) begin
        sum = sum + TeaDelta;
        sel = (sum >> 2) & 32'd3;
        v0  = v0 + round_mix(v1, v1, sum, 0, sel);
        v1  = v1 + round_mix(v0, v0, sum, 1, sel);
      end
    end else begin
      sum = word_t'(Rounds * TeaDelta);
      for (int unsigned r = 0; r < Rounds; r++) begin
        sel = (sum >> 2) & 32'd3;
        v1  = v1 - round_mix(v0, v0, sum, 1, sel);
        v0  = v0 - round_mix(v1, v1, sum, 0, sel);
        sum = sum - TeaDelta;
      end
    end
    res.w0 = v0;
    res.w1 = v1;
    return res;
  endfunction

  // Count a failure; print only the first few
  task automatic note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MaxReports) begin
      $display("mismatch at %0t: %s", $time, msg);
    end
  endtask

  // Stall the output at random and check each accepted result transaction
  always @(posedge clk_i) begin : check_results
    cipher_block_t want;
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_blocks.size() == 0) begin
        note_mismatch($sformatf("unexpected result %08h %08h", result_word0_o,
                                result_word1_o));
      end else begin
        want = expected_blocks.pop_front();
        if (result_word0_o !== want.w0) begin
          note_mismatch($sformatf("result_word0 expected %08h got %08h", want.w0,
                                  result_word0_o));
        end
        if (result_word1_o !== want.w1) begin
          note_mismatch($sformatf("result_word1 expected %08h got %08h", want.w1,
                                  result_word1_o));
        end
      end
    end
  end

  // Send one block transaction; valid stays high if the next one follows directly
  task automatic send_block(word_t w0, word_t w1);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    block_word0_i <= w0;
    block_word1_i <= w1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_blocks.push_back(xxtea_transform(w0, w1));
  endtask

  // Drop valid and wait until every block in flight has come out
  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_blocks.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  // Write one register transaction and mirror it in the model; valid is left high
  task automatic write_reg(cfg_addr_e addr, word_t data);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (addr)
      CfgKeyWord0:    key_model[0] = data;
      CfgKeyWord1:    key_model[1] = data;
      CfgKeyWord2:    key_model[2] = data;
      CfgKeyWord3:    key_model[3] = data;
      CfgDecryptMode: decipher_model = data[0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_config(word_t k0, word_t k1, word_t k2, word_t k3, word_t mode);
    settle();
    write_reg(CfgKeyWord0, k0);
    write_reg(CfgKeyWord1, k1);
    write_reg(CfgKeyWord2, k2);
    write_reg(CfgKeyWord3, k3);
    write_reg(CfgDecryptMode, mode);
    end_writes();
  endtask

  // Random word biased toward zero, all ones, single set bits and single cleared bits
  function automatic word_t pick_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return word_t'(1) << $urandom_range(WordWidth - 1);
      3:       return ~(word_t'(1) << $urandom_range(WordWidth - 1));
      default: return $urandom();
    endcase
  endfunction

  // Extreme blocks under the key that reset leaves
  task automatic test_reset_key();
    send_block('0, '0);
    send_block('1, '1);
    send_block('0, '1);
    send_block('1, '0);
    send_block(32'h8000_0000, 32'h0000_0001);
    send_block(32'h0123_4567, 32'h89AB_CDEF);
  endtask

  // All-zero and all-one keys in both directions
  task automatic test_key_extremes();
    load_config('0, '0, '0, '0, 32'd0);
    send_block('0, '0);
    send_block('1, '1);
    load_config('1, '1, '1, '1, 32'd0);
    send_block('0, '0);
    send_block('1, '1);
    load_config('1, '1, '1, '1, 32'd1);
    send_block('0, '0);
    send_block('1, '1);
    load_config('0, '0, '0, '0, 32'd1);
    send_block('0, '1);
    send_block('1, '0);
  endtask

  // Decipher under the reset key, including the ciphertext of a known block
  task automatic test_decrypt_path();
    cipher_block_t ct;
    load_config(KeyReset0, KeyReset1, KeyReset2, KeyReset3, 32'd0);
    ct = xxtea_transform(32'hDEAD_BEEF, 32'h0BAD_F00D);
    settle();
    write_reg(CfgDecryptMode, 32'd1);
    end_writes();
    send_block(ct.w0, ct.w1);
    send_block('0, '0);
    send_block('1, '1);
  endtask

  // Writes past the last register are dropped; the mode keeps only its low bit
  task automatic test_register_edges();
    settle();
    for (int unsigned k = 1; k <= 3; k++) begin
      write_reg(cfg_addr_e'(CfgDecryptMode + k), '1);
    end
    write_reg(CfgDecryptMode, 32'hFFFF_FFFE);
    end_writes();
    send_block(32'h1234_5678, 32'h9ABC_DEF0);
    settle();
    write_reg(CfgDecryptMode, 32'h8000_0003);
    end_writes();
    send_block(32'h1234_5678, 32'h9ABC_DEF0);
  endtask

  // Random blocks in three idling phases, with a fresh configuration every chunk
  task automatic test_random_traffic();
    int unsigned send_pct [3] = '{31, 67, 0};
    int unsigned recv_pct [3] = '{67, 31, 0};
    for (int ph = 0; ph < 3; ph++) begin
      settle();
      send_idle_pct  = send_pct[ph];
      recv_stall_pct = recv_pct[ph];
      for (int chunk = 0; chunk < 5; chunk++) begin
        load_config(pick_word(), pick_word(), pick_word(), pick_word(),
                    $urandom_range(1));
        for (int n = 0; n < 100; n++) begin
          send_block(pick_word(), pick_word());
        end
      end
    end
  endtask

  // Run the tests in turn and report
  initial begin
    key_model[0]   = KeyReset0;
    key_model[1]   = KeyReset1;
    key_model[2]   = KeyReset2;
    key_model[3]   = KeyReset3;
    decipher_model = 1'b0;
    send_idle_pct  = 31;
    recv_stall_pct = 67;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_key();
    test_key_extremes();
    test_decrypt_path();
    test_register_edges();
    test_random_traffic();

    settle();
    repeat (Latency) @(posedge clk_i);
    if (expected_blocks.size() != 0) begin
      note_mismatch($sformatf("%0d results never arrived", expected_blocks.size()));
    end
    if (mismatch_count == 0) begin
      $display("** xxtea_block_cipher_64_core: PASSED **");
    end else begin
      $display("** xxtea_block_cipher_64_core: FAILED **");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #400000;
    $display("** xxtea_block_cipher_64_core: FAILED **");
    $finish;
  end

endmodule
